// ===== hdl/tua_pkg.sv =====
// Shared types and constants for the tagged usage accumulator.
package tua_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int TAG_W       = 31;
    localparam int SUM_W       = 32;
    localparam int USED_W      = 7;
    localparam int SLOT_W      = 6;
    localparam logic [31:0] TAG_MASK = 32'h7f7f7f7f;

    typedef enum logic [1:0] {
        OP_ACCOUNT = 2'd0,
        OP_READ    = 2'd1,
        OP_TOTALS  = 2'd2,
        OP_CLEAR   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_DROPPED = 2'd2,
        ST_BEYOND  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_READ
    } t_state;

    typedef struct packed {
        t_opcode     opcode;
        logic        pool_kind;
        logic        block_failed;
        logic        has_header;
        logic        quota_block;
        logic [31:0] block_tag;
        logic [31:0] block_size;
        logic [5:0]  entry_index;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [30:0] tag_out;
        logic [31:0] paged_sum;
        logic [31:0] nonpaged_sum;
        logic [31:0] paged_errors;
        logic [31:0] nonpaged_errors;
        logic [6:0]  entries_used;
        logic [5:0]  slot_out;
    } t_out;

    // One table entry as stored in RAM
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [SUM_W-1:0] paged;
        logic [SUM_W-1:0] nonpaged;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic emit_simple;
        logic emit_read;
        logic emit_full;
        logic append;
        logic update;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic search;
        logic read_op;
        logic index_ok;
        logic scan_end;
        logic full;
        logic hit;
    } t_sts;

endpackage

// ===== hdl/tua_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tua_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tua_datapath.sv =====
// Datapath: latched transaction, entry table RAM, counters and result register.
module tua_datapath
    import tua_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_item,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output logic o_strobe,
    output t_out o_result
);

    t_in              r_item;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx;
    logic [IDX_W-1:0] r_cmp_idx;
    logic             r_cmp_vld;
    logic [SUM_W-1:0] r_quota [2];
    logic [SUM_W-1:0] r_err   [2];
    logic [SUM_W-1:0] n_quota [2];
    logic [SUM_W-1:0] n_err   [2];
    logic             r_strobe;
    t_out             r_out, n_out;

    logic [TAG_W-1:0] masked_tag;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_en;
    t_entry           rd_entry, wr_entry;
    logic [ENTRY_W-1:0] rd_data;
    logic             emit_any;

    assign masked_tag = TAG_W'(r_item.block_tag & TAG_MASK);
    assign rd_entry   = t_entry'(rd_data);
    assign emit_any   = i_cmd.emit_simple | i_cmd.emit_read | i_cmd.emit_full |
                        i_cmd.append | i_cmd.update;

    assign rd_addr = (r_item.opcode == OP_READ) ? IDX_W'(r_item.entry_index)
                                                : r_idx[IDX_W-1:0];
    assign wr_en   = i_cmd.append | i_cmd.update;
    assign wr_addr = i_cmd.append ? r_count[IDX_W-1:0] : r_cmp_idx;

    tua_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (ENTRY_W'(wr_entry)),
        .i_re    (i_cmd.rd),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Status toward the controller
    always_comb begin
        o_sts.search   = (r_item.opcode == OP_ACCOUNT) && !r_item.block_failed &&
                         r_item.has_header && !r_item.quota_block;
        o_sts.read_op  = (r_item.opcode == OP_READ);
        o_sts.index_ok = 32'(r_item.entry_index) < 32'(r_count);
        o_sts.scan_end = (r_idx >= r_count);
        o_sts.full     = (r_count == CNT_W'(TABLE_DEPTH));
        o_sts.hit      = r_cmp_vld && (rd_entry.tag == masked_tag);
    end

    // Table entry written by append or update
    always_comb begin
        wr_entry = rd_entry;
        if (i_cmd.append) begin
            wr_entry.tag      = masked_tag;
            wr_entry.paged    = r_item.pool_kind ? '0 : r_item.block_size;
            wr_entry.nonpaged = r_item.pool_kind ? r_item.block_size : '0;
        end else if (r_item.pool_kind) begin
            wr_entry.nonpaged = rd_entry.nonpaged + r_item.block_size;
        end else begin
            wr_entry.paged = rd_entry.paged + r_item.block_size;
        end
    end

    // Counters and result
    always_comb begin
        n_count  = r_count;
        n_quota  = r_quota;
        n_err    = r_err;
        n_out    = '0;
        n_out.status       = ST_DONE;
        n_out.entries_used = USED_W'(r_count);

        if (i_cmd.emit_simple) begin
            unique case (r_item.opcode)
                OP_ACCOUNT: begin
                    if (r_item.block_failed) begin
                        n_err[r_item.pool_kind] = r_err[r_item.pool_kind] + 1'b1;
                    end else if (!r_item.has_header) begin
                        n_out.status = ST_IGNORED;
                    end else begin
                        n_quota[r_item.pool_kind] = r_quota[r_item.pool_kind] +
                                                    r_item.block_size;
                    end
                end
                OP_TOTALS: begin
                    n_out.paged_sum       = r_quota[0];
                    n_out.nonpaged_sum    = r_quota[1];
                    n_out.paged_errors    = r_err[0];
                    n_out.nonpaged_errors = r_err[1];
                end
                OP_CLEAR: begin
                    n_count            = '0;
                    n_quota            = '{default: '0};
                    n_err              = '{default: '0};
                    n_out.entries_used = '0;
                end
                default: begin
                    n_out.status = ST_BEYOND;
                end
            endcase
        end else if (i_cmd.emit_read) begin
            if (o_sts.index_ok) begin
                n_out.tag_out      = rd_entry.tag;
                n_out.paged_sum    = rd_entry.paged;
                n_out.nonpaged_sum = rd_entry.nonpaged;
            end else begin
                n_out.status = ST_BEYOND;
            end
        end else if (i_cmd.emit_full) begin
            n_out.status  = ST_DROPPED;
            n_out.tag_out = masked_tag;
        end else if (i_cmd.append) begin
            n_count            = r_count + 1'b1;
            n_out.tag_out      = masked_tag;
            n_out.paged_sum    = wr_entry.paged;
            n_out.nonpaged_sum = wr_entry.nonpaged;
            n_out.slot_out     = SLOT_W'(r_count);
            n_out.entries_used = USED_W'(n_count);
        end else if (i_cmd.update) begin
            n_out.tag_out      = masked_tag;
            n_out.paged_sum    = wr_entry.paged;
            n_out.nonpaged_sum = wr_entry.nonpaged;
            n_out.slot_out     = SLOT_W'(r_cmp_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_quota   <= '{default: '0};
            r_err     <= '{default: '0};
            r_strobe  <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_count   <= n_count;
            r_quota   <= n_quota;
            r_err     <= n_err;
            r_strobe  <= emit_any;
            // read data lines up with r_cmp_idx in the cycle after each scan read
            r_cmp_vld <= i_cmd.rd;
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.rd) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.rd) begin
            r_cmp_idx <= r_idx[IDX_W-1:0];
        end
        if (emit_any) begin
            r_out <= n_out;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |=> r_count == $past(r_count) + 1'b1)
        else $error("append did not grow the table");

    a_no_append_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> !o_sts.full)
        else $error("append into a full table");

    a_update_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> o_sts.hit)
        else $error("update without a tag match");

endmodule

// ===== hdl/tua_ctrl.sv =====
// Controller state machine: sequences decode, table scan, reads and result issue.
module tua_ctrl
    import tua_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.search) begin
                    n_state = S_SCAN;
                end else if (i_sts.read_op) begin
                    if (i_sts.index_ok) begin
                        o_cmd.rd = 1'b1;
                        n_state  = S_READ;
                    end else begin
                        o_cmd.emit_read = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    o_cmd.emit_simple = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_SCAN: begin
                // one read issued and one compare done per cycle
                if (i_sts.hit) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end else if (!i_sts.scan_end) begin
                    o_cmd.rd = 1'b1;
                end else if (i_sts.full) begin
                    o_cmd.emit_full = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.append = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.emit_read = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.emit_simple, o_cmd.emit_read, o_cmd.emit_full,
                  o_cmd.append, o_cmd.update}))
        else $error("more than one result issued in a cycle");

    a_done_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_busy && n_state == S_IDLE) |->
            (o_cmd.emit_simple || o_cmd.emit_read || o_cmd.emit_full ||
             o_cmd.append || o_cmd.update))
        else $error("transaction finished without a result");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_DECODE)
        else $error("load did not enter decode");

endmodule

// ===== hdl/tagged_usage_accumulator.sv =====
// Top level of the tagged usage accumulator.
// One transaction is taken when start is high while busy is low; its result
// appears in the cycle busy drops, on o_result with o_strobe high for exactly
// one cycle, and cannot be held off. Totals, clear, ignored, failed and quota
// records pass the load and decode states before the result; an in-range entry
// read adds a read state for the RAM's registered read port. An account record
// scans the tag table one entry per cycle through that port until a tag hit
// updates the entry, or the scan ends and the tag is appended or, if full, dropped.
// A new transaction may start in the cycle the previous result is strobed.
module tagged_usage_accumulator
    import tua_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_item,
    output logic busy,
    output logic o_strobe,
    output t_out o_result
);

    t_cmd cmd;
    t_sts sts;

    tua_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    tua_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the tagged usage accumulator with directed and random traffic.
module tb_top;
    import tua_pkg::*;

    localparam int WATCHDOG = 2000;

    // Tracks the usage table, the quota sums and the error counts, and holds
    // the results still to come from the block.
    class usage_scoreboard;
        logic [30:0] tags[TABLE_DEPTH];
        logic [31:0] paged_use[TABLE_DEPTH];
        logic [31:0] nonpaged_use[TABLE_DEPTH];
        logic [31:0] quota[2];
        logic [31:0] errs[2];
        int          used;
        t_out        pending[$];
        int          errors;
        int          shown;

        function new();
            used     = 0;
            quota[0] = '0;
            quota[1] = '0;
            errs[0]  = '0;
            errs[1]  = '0;
            errors   = 0;
            shown    = 0;
        endfunction

        function void note_item(t_in it);
            t_out        r;
            logic [31:0] mtag;
            int          slot;
            r = '0;
            case (it.opcode)
                OP_ACCOUNT: begin
                    mtag = it.block_tag & TAG_MASK;
                    // failure wins over the header and quota flags
                    if (it.block_failed) begin
                        errs[it.pool_kind] += 32'd1;
                    end else if (!it.has_header) begin
                        r.status = ST_IGNORED;
                    end else if (it.quota_block) begin
                        quota[it.pool_kind] += it.block_size;
                    end else begin
                        r.tag_out = mtag[30:0];
                        slot = -1;
                        for (int i = 0; i < used; i++) begin
                            if (slot < 0 && tags[i] == mtag[30:0]) slot = i;
                        end
                        if (slot < 0 && used >= TABLE_DEPTH) begin
                            r.status = ST_DROPPED;
                        end else begin
                            if (slot < 0) begin
                                slot               = used;
                                tags[slot]         = mtag[30:0];
                                paged_use[slot]    = '0;
                                nonpaged_use[slot] = '0;
                                used++;
                            end
                            if (it.pool_kind) nonpaged_use[slot] += it.block_size;
                            else paged_use[slot] += it.block_size;
                            r.paged_sum    = paged_use[slot];
                            r.nonpaged_sum = nonpaged_use[slot];
                            r.slot_out     = slot[5:0];
                        end
                    end
                end
                OP_READ: begin
                    if (int'(it.entry_index) >= used) begin
                        r.status = ST_BEYOND;
                    end else begin
                        r.tag_out      = tags[it.entry_index];
                        r.paged_sum    = paged_use[it.entry_index];
                        r.nonpaged_sum = nonpaged_use[it.entry_index];
                    end
                end
                OP_TOTALS: begin
                    r.paged_sum       = quota[0];
                    r.nonpaged_sum    = quota[1];
                    r.paged_errors    = errs[0];
                    r.nonpaged_errors = errs[1];
                end
                default: begin
                    used     = 0;
                    quota[0] = '0;
                    quota[1] = '0;
                    errs[0]  = '0;
                    errs[1]  = '0;
                end
            endcase
            r.entries_used = used[6:0];
            pending.push_back(r);
        endfunction

        function string fmt(t_out r);
            return $sformatf("st=%0d tag=%h p=%h np=%h pe=%h npe=%h used=%0d slot=%0d",
                             r.status, r.tag_out, r.paged_sum, r.nonpaged_sum,
                             r.paged_errors, r.nonpaged_errors, r.entries_used, r.slot_out);
        endfunction

        function void check_result(t_out got);
            t_out exp;
            if (pending.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected result: %s", fmt(got));
                end
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status || got.tag_out !== exp.tag_out ||
                got.paged_sum !== exp.paged_sum || got.nonpaged_sum !== exp.nonpaged_sum ||
                got.paged_errors !== exp.paged_errors ||
                got.nonpaged_errors !== exp.nonpaged_errors ||
                got.entries_used !== exp.entries_used || got.slot_out !== exp.slot_out) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("result mismatch: expected %s", fmt(exp));
                    $display("                 actual   %s", fmt(got));
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_in  i_item;
    logic busy;
    logic o_strobe;
    t_out o_result;

    usage_scoreboard sb = new();
    int idle_cycles = 0;
    int burst_left;
    int sent;

    tagged_usage_accumulator i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Sample at the rising edge; inputs only move on the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) sb.check_result(o_result);
            if (start && !busy) sb.note_item(i_item);
            if (o_strobe || (start && !busy)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic t_in acct(logic pool, logic failed, logic hdr, logic quo,
                                 logic [31:0] tag, logic [31:0] size);
        t_in it;
        it              = '0;
        it.opcode       = OP_ACCOUNT;
        it.pool_kind    = pool;
        it.block_failed = failed;
        it.has_header   = hdr;
        it.quota_block  = quo;
        it.block_tag    = tag;
        it.block_size   = size;
        it.entry_index  = 6'($urandom);
        return it;
    endfunction

    function automatic t_in op_item(t_opcode op, logic [5:0] idx);
        t_in it;
        it             = acct(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                              $urandom, $urandom);
        it.opcode      = op;
        it.entry_index = idx;
        return it;
    endfunction

    function automatic logic [31:0] rand_size();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 255));
            1: return $urandom;
            2: return 32'hffff_ff00 | 32'($urandom_range(0, 255));
            default: return 32'($urandom_range(0, 65535));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    // The sender runs in bursts, with idle gaps of random length before most bursts.
    task automatic send(t_in it);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 80)
                                                  : $urandom_range(1, 6);
                start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        start  <= 1'b1;
        i_item <= it;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    // One stretch of traffic over a pool of tags; large pools overflow the table.
    task automatic run_phase();
        logic [31:0] pool[80];
        int          psize;
        int          n;
        int          r;
        int          top;
        t_in         it;
        if ($urandom_range(0, 2) == 0) send(op_item(OP_CLEAR, 6'd0));
        psize = ($urandom_range(0, 4) == 0) ? $urandom_range(65, 80) : $urandom_range(1, 16);
        for (int i = 0; i < psize; i++) pool[i] = $urandom & TAG_MASK;
        n = (psize > 64) ? $urandom_range(120, 160) : $urandom_range(20, 60);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 68) begin
                // aliasing bits outside the mask still hit the same entry
                it = acct(1'($urandom), 1'b0, 1'b1, 1'b0,
                          pool[$urandom_range(0, psize - 1)] | ($urandom & ~TAG_MASK),
                          rand_size());
            end else if (r < 78) begin
                top = (sb.used > 63) ? 63 : sb.used;
                it  = op_item(OP_READ, ($urandom_range(0, 3) == 0) ? 6'($urandom)
                                                                   : 6'($urandom_range(0, top)));
            end else if (r < 84) begin
                it = op_item(OP_TOTALS, 6'($urandom));
            end else if (r < 94) begin
                it = acct(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                          $urandom, rand_size());
            end else if (r < 96) begin
                it = op_item(OP_CLEAR, 6'($urandom));
            end else begin
                it = op_item(t_opcode'($urandom_range(0, 3)), 6'($urandom));
            end
            send(it);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        burst_left  = 0;
        sent        = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty state, flag precedence, masking, wrap, table reads
        send(op_item(OP_TOTALS, 6'd0));
        send(op_item(OP_READ, 6'd0));
        send(acct(1'b0, 1'b0, 1'b0, 1'b1, 32'hdead_beef, 32'd10));
        send(acct(1'b0, 1'b1, 1'b1, 1'b1, 32'hffff_ffff, 32'hffff_ffff));
        send(acct(1'b1, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0));
        send(acct(1'b0, 1'b0, 1'b1, 1'b1, 32'h1234_5678, 32'hffff_ffff));
        send(acct(1'b1, 1'b0, 1'b1, 1'b1, 32'h0, 32'd1));
        send(acct(1'b0, 1'b0, 1'b1, 1'b1, 32'h0, 32'd1));
        send(op_item(OP_TOTALS, 6'h3f));
        send(acct(1'b0, 1'b0, 1'b1, 1'b0, 32'hffff_ffff, 32'hffff_ffff));
        send(acct(1'b1, 1'b0, 1'b1, 1'b0, 32'h8080_8080, 32'd5));
        send(acct(1'b1, 1'b0, 1'b1, 1'b0, 32'h7f7f_7f7f, 32'd1));
        send(acct(1'b0, 1'b0, 1'b1, 1'b0, 32'hff7f_ff7f, 32'd1));
        send(acct(1'b1, 1'b0, 1'b1, 1'b0, 32'h0000_0000, 32'hffff_fffb));
        send(op_item(OP_READ, 6'd0));
        send(op_item(OP_READ, 6'd1));
        send(op_item(OP_READ, 6'd2));
        send(op_item(OP_READ, 6'h3f));
        send(op_item(OP_CLEAR, 6'd0));
        send(op_item(OP_TOTALS, 6'd0));
        send(op_item(OP_READ, 6'd0));

        while (sent < 1300) run_phase();

        start <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (TABLE_DEPTH + 8) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
